FILE: hw/rtl/chfr_pkg.sv
// Shared types and constants for the compass heading pipeline.
package chfr_pkg;

  // CORDIC angle accumulator: Q24 radians, signed, covers -pi/2 .. 2*pi
  localparam int ANGLE_W        = 28;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int FRAC_DROP      = 11;

  localparam logic signed [ANGLE_W-1:0] PI_Q24     = 28'sd52707179;
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q24 = 28'sd105414357;
  localparam logic signed [ANGLE_W-1:0] ROUND_HALF = 28'sd1024;

  localparam int HEADING_W = 16;
  localparam int H_FULL_W  = ANGLE_W - FRAC_DROP;
  localparam logic [H_FULL_W-1:0] HEADING_FULL_TURN = 17'd51472;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Z = 2'd1,
    REG_SCALE_X  = 2'd2,
    REG_SCALE_Z  = 2'd3
  } cfg_reg_t;

  // control bits that ride along with each pipeline beat
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ANGLE_W-1:0] atan_q24(input int i);
    logic signed [ANGLE_W-1:0] a;
    unique case (i)
      0:       a = 28'sd13176795;
      1:       a = 28'sd7778716;
      2:       a = 28'sd4110060;
      3:       a = 28'sd2086331;
      4:       a = 28'sd1047214;
      5:       a = 28'sd524117;
      6:       a = 28'sd262123;
      7:       a = 28'sd131069;
      8:       a = 28'sd65536;
      9:       a = 28'sd32768;
      10:      a = 28'sd16384;
      11:      a = 28'sd8192;
      12:      a = 28'sd4096;
      13:      a = 28'sd2048;
      14:      a = 28'sd1024;
      15:      a = 28'sd512;
      16:      a = 28'sd256;
      17:      a = 28'sd128;
      18:      a = 28'sd64;
      19:      a = 28'sd32;
      20:      a = 28'sd16;
      21:      a = 28'sd8;
      22:      a = 28'sd4;
      23:      a = 28'sd2;
      default: a = 28'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/chfr_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
module chfr_cordic_stage
  import chfr_pkg::*;
#(
  parameter int W     = 36,
  parameter int SHIFT = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctl_t                      ctl_in,
  input  logic signed [W-1:0]       x_in,
  input  logic signed [W-1:0]       y_in,
  input  logic signed [ANGLE_W-1:0] angle_in,
  output ctl_t                      ctl_out,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic signed [ANGLE_W-1:0] angle_out
);

  localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = atan_q24(SHIFT);

  logic signed [W-1:0]       xs;
  logic signed [W-1:0]       ys;
  logic signed [W-1:0]       x_next;
  logic signed [W-1:0]       y_next;
  logic signed [ANGLE_W-1:0] angle_next;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    if (!y_in[W-1]) begin
      x_next     = x_in + ys;
      y_next     = y_in - xs;
      angle_next = angle_in + STEP_ANGLE;
    end else begin
      x_next     = x_in - ys;
      y_next     = y_in + xs;
      angle_next = angle_in - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    x_out     <= x_next;
    y_out     <= y_next;
    angle_out <= angle_next;
  end

endmodule

FILE: hw/rtl/compass_heading_from_raw.sv
// Top level: calibrated magnetometer sample to compass heading, fully pipelined.
//
// Input: raw_x/raw_z are taken at a rising edge with start high and busy low.
// busy is high only while rst is asserted, so a new sample may be issued every
// cycle outside reset.
// Config: cfg_valid/cfg_ready write channel, cfg_index selects offset_x,
// offset_z, scale_x or scale_z; cfg_ready is always high. Write registers
// only while no sample is in flight.
// Output: heading (radians, 13 fractional bits) is valid for exactly one
// cycle, flagged by done. The receiver cannot stall; one result per sample.
// Pipeline: offset subtract, cross multiply, pre-rotation, one register per
// CORDIC micro-rotation, final wrap and round, each registered in that order.
// Throughput: one sample per cycle outside reset, set by the one-rotation-per-stage chain.
// Reset: synchronous rst drops all in-flight beats and restores offsets to 0
// and scales to 2.
module compass_heading_from_raw
  import chfr_pkg::*;
#(
  parameter int RAW_BITS      = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [RAW_BITS-1:0]   raw_x,
  input  logic [RAW_BITS-1:0]   raw_z,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [RAW_BITS:0]     cfg_data,
  output logic                  done,
  output logic [HEADING_W-1:0]  heading
);

  localparam int DW      = RAW_BITS + 2;       // corrected axis
  localparam int PW      = 2 * RAW_BITS + 2;   // cross product
  localparam int W       = 2 * RAW_BITS + 4;   // CORDIC datapath, room for gain
  localparam int LATENCY = CORDIC_STAGES + 4;

  // configuration registers
  logic signed [RAW_BITS:0]   offset_x;
  logic signed [RAW_BITS:0]   offset_z;
  logic        [RAW_BITS-1:0] scale_x;
  logic        [RAW_BITS-1:0] scale_z;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_z <= '0;
      scale_x  <= RAW_BITS'(2);
      scale_z  <= RAW_BITS'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        REG_SCALE_X:  scale_x  <= cfg_data[RAW_BITS-1:0];
        REG_SCALE_Z:  scale_z  <= cfg_data[RAW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: dx = 2*raw - offset
  logic              s1_valid;
  logic signed [DW-1:0] s1_dx;
  logic signed [DW-1:0] s1_dz;
  logic signed [DW-1:0] dx_next;
  logic signed [DW-1:0] dz_next;

  assign dx_next = $signed({raw_x[RAW_BITS-1], raw_x, 1'b0}) -
                   $signed({offset_x[RAW_BITS], offset_x});
  assign dz_next = $signed({raw_z[RAW_BITS-1], raw_z, 1'b0}) -
                   $signed({offset_z[RAW_BITS], offset_z});

  // stage 2: cross products
  logic              s2_valid;
  logic signed [PW-1:0] s2_x;
  logic signed [PW-1:0] s2_y;
  logic signed [PW-1:0] x_prod;
  logic signed [PW-1:0] y_prod;

  assign x_prod = PW'(s1_dx) * PW'($signed({1'b0, scale_z}));
  assign y_prod = PW'(s1_dz) * PW'($signed({1'b0, scale_x}));

  // stage 3: fold left half-plane into the right, flag the zero vector
  logic signed [W-1:0]       x_ext;
  logic signed [W-1:0]       y_ext;

  assign x_ext = W'(s2_x);
  assign y_ext = W'(s2_y);

  ctl_t                      rot_ctl   [CORDIC_STAGES+1];
  logic signed [W-1:0]       rot_x     [CORDIC_STAGES+1];
  logic signed [W-1:0]       rot_y     [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] rot_angle [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      rot_ctl[0] <= '0;
    end else begin
      s1_valid         <= start && !busy;
      s2_valid         <= s1_valid;
      rot_ctl[0].valid <= s2_valid;
      rot_ctl[0].zero  <= (s2_x == '0) && (s2_y == '0);
    end
  end

  always_ff @(posedge clk) begin
    s1_dx <= dx_next;
    s1_dz <= dz_next;
    s2_x  <= x_prod;
    s2_y  <= y_prod;
    if (s2_x[PW-1]) begin
      rot_x[0]     <= -x_ext;
      rot_y[0]     <= -y_ext;
      rot_angle[0] <= PI_Q24;
    end else begin
      rot_x[0]     <= x_ext;
      rot_y[0]     <= y_ext;
      rot_angle[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    chfr_cordic_stage #(
      .W     (W),
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (rot_ctl[i]),
      .x_in      (rot_x[i]),
      .y_in      (rot_y[i]),
      .angle_in  (rot_angle[i]),
      .ctl_out   (rot_ctl[i+1]),
      .x_out     (rot_x[i+1]),
      .y_out     (rot_y[i+1]),
      .angle_out (rot_angle[i+1])
    );
  end

  // final stage: wrap into [0, 2pi), round to 13 fractional bits
  ctl_t                      fin_ctl;
  logic signed [ANGLE_W-1:0] fin_angle;
  logic signed [ANGLE_W-1:0] wrapped;
  logic signed [ANGLE_W-1:0] rounded;
  logic [H_FULL_W-1:0]       h_full;
  logic [HEADING_W-1:0]      heading_next;

  assign fin_ctl   = rot_ctl[CORDIC_STAGES];
  assign fin_angle = rot_angle[CORDIC_STAGES];

  always_comb begin
    wrapped = fin_angle[ANGLE_W-1] ? fin_angle + TWO_PI_Q24 : fin_angle;
    rounded = wrapped + ROUND_HALF;
    h_full  = rounded[ANGLE_W-1:FRAC_DROP];
    if (fin_ctl.zero || (h_full >= HEADING_FULL_TURN)) begin
      heading_next = '0;
    end else begin
      heading_next = h_full[HEADING_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    heading <= heading_next;
  end

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (heading < HEADING_W'(HEADING_FULL_TURN)))
    else $error("heading beyond a full turn");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted beat");
`endif

endmodule
